>>> rtl/tcce_pkg.sv
package tcce_pkg;

    // screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;
    localparam int AW      = $clog2(CELLS);
    localparam int CNT_W   = $clog2(CELLS + 1);

    // field widths
    localparam int MODE_W = 2;
    localparam int CODE_W = 8;
    localparam int IDX_W  = 11;
    localparam int X_W    = 7;
    localparam int Y_W    = 5;
    localparam int ATTR_W = 8;
    localparam int DATA_W = 16;
    localparam int OFF_W  = 11;

    // command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;
    localparam logic [CODE_W-1:0] BLANK_CHAR = 8'h20;
    localparam int                TAB_STEP   = 4;

    // mode codes
    localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SET   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd3;

    // control characters and printable range
    localparam logic [CODE_W-1:0] CH_BS       = 8'd8;
    localparam logic [CODE_W-1:0] CH_TAB      = 8'd9;
    localparam logic [CODE_W-1:0] CH_LF       = 8'd10;
    localparam logic [CODE_W-1:0] CH_CR       = 8'd13;
    localparam logic [CODE_W-1:0] CH_PRINT_LO = 8'd32;
    localparam logic [CODE_W-1:0] CH_PRINT_HI = 8'd127;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_PUT,
        OP_CR,
        OP_LF,
        OP_BS,
        OP_TAB,
        OP_READ,
        OP_SET,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [CODE_W-1:0] char_code;
        logic [IDX_W-1:0]  cell_index;
        logic [X_W-1:0]    col;
        logic [Y_W-1:0]    row;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_FILL,
        ST_IDLE,
        ST_EXEC,
        ST_EMIT
    } t_state;

    // add two cell addresses modulo the store size (both below CELLS)
    function automatic logic [AW-1:0] cell_wrap(input logic [AW-1:0] a,
                                                input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (AW+1)'(CELLS)) begin
            s = s - (AW+1)'(CELLS);
        end
        return s[AW-1:0];
    endfunction

endpackage

>>> rtl/text_console_character_engine.sv
// Text console: a store of attribute/character cells plus a cursor.
// Input channel (i_in_valid / o_in_stall) takes one word per command:
// mode 0 puts a character, 1 reads a cell, 2 places the cursor, 3 clears.
// Output channel (o_out_valid / i_out_stall) returns one word per command:
// the cell read (zero for other modes) and the cursor offset afterwards.
// Configuration channel (i_cfg_valid / o_cfg_ready) writes the attribute
// byte used for written, blanked and cleared cells; it is always ready.
// A plain command passes from the queue through the EXEC and EMIT states
// into the output register; the back end pops the next command as it
// emits the last one. A scroll adds one row of blanking (COLUMNS cells),
// a clear adds a sweep of the whole store (CELLS cells): the store
// has a single write port and blanks one cell per cycle.
// After reset the store is blanked in one pass with attribute 7;
// input words queue up meanwhile (two deep) and are then processed.
// When the receiver stalls, the result waits in the output register; the
// back end stops after the next command and the queue then fills.
module text_console_character_engine (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [tcce_pkg::MODE_W-1:0]    i_mode,
    input  logic [tcce_pkg::CODE_W-1:0]    i_char_code,
    input  logic [tcce_pkg::IDX_W-1:0]     i_cell_index,
    input  logic [tcce_pkg::X_W-1:0]       i_target_column,
    input  logic [tcce_pkg::Y_W-1:0]       i_target_row,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [tcce_pkg::DATA_W-1:0]    o_cell_data,
    output logic [tcce_pkg::OFF_W-1:0]     o_cursor_offset,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tcce_pkg::ATTR_W-1:0]    i_cfg_data
);
    import tcce_pkg::*;

    logic [ATTR_W-1:0] r_attr;
    logic              push;
    logic              pop;
    logic              full;
    logic              empty;
    t_cmd              front_cmd;
    t_cmd              head_cmd;

    assign o_cfg_ready = 1'b1;

    // attribute register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= RESET_ATTR;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_attr <= i_cfg_data;
        end
    end

    tcce_front u_front (
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_mode          (i_mode),
        .i_char_code     (i_char_code),
        .i_cell_index    (i_cell_index),
        .i_target_column (i_target_column),
        .i_target_row    (i_target_row),
        .i_full          (full),
        .o_push          (push),
        .o_cmd           (front_cmd)
    );

    tcce_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_empty (empty)
    );

    tcce_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_attr          (r_attr),
        .i_empty         (empty),
        .i_cmd           (head_cmd),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_cell_data     (o_cell_data),
        .o_cursor_offset (o_cursor_offset)
    );

`ifndef SYNTHESIS
    // reported cursor always lies on the screen
    a_offset_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> int'(o_cursor_offset) < CELLS)
        else $error("cursor offset beyond the screen");

    // no result while reset is applied or straight after it (blanking pass runs)
    a_no_word_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word during reset blanking");

    // queue never pops when empty nor pushes when full
    a_queue_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(pop && empty) && !(push && full))
        else $error("command queue overrun");
`endif

endmodule

>>> rtl/tcce_queue.sv
module tcce_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tcce_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output tcce_pkg::t_cmd o_cmd,
    output logic           o_empty
);
    import tcce_pkg::*;

    t_cmd           r_mem [QDEPTH];
    logic [QAW-1:0] r_wr_ptr;
    logic [QAW-1:0] r_rd_ptr;
    logic [QAW:0]   r_count;

    assign o_full  = (r_count == (QAW+1)'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> rtl/tcce_front.sv
module tcce_front (
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [tcce_pkg::MODE_W-1:0]    i_mode,
    input  logic [tcce_pkg::CODE_W-1:0]    i_char_code,
    input  logic [tcce_pkg::IDX_W-1:0]     i_cell_index,
    input  logic [tcce_pkg::X_W-1:0]       i_target_column,
    input  logic [tcce_pkg::Y_W-1:0]       i_target_row,
    input  logic                           i_full,
    output logic                           o_push,
    output tcce_pkg::t_cmd                 o_cmd
);
    import tcce_pkg::*;

    t_op op;

    assign o_in_stall = i_full;
    assign o_push     = i_in_valid && !i_full;

    // classify the word into a back-end operation
    always_comb begin
        unique case (i_mode)
            MODE_PUT: begin
                unique case (i_char_code) inside
                    CH_BS:                      op = OP_BS;
                    CH_TAB:                     op = OP_TAB;
                    CH_LF:                      op = OP_LF;
                    CH_CR:                      op = OP_CR;
                    [CH_PRINT_LO:CH_PRINT_HI]:  op = OP_PUT;
                    default:                    op = OP_NOP;
                endcase
            end
            MODE_READ: op = OP_READ;
            MODE_SET:  op = OP_SET;
            default:   op = OP_CLEAR;
        endcase
    end

    // payload, cursor target saturated to the screen
    always_comb begin
        o_cmd.op         = op;
        o_cmd.char_code  = i_char_code;
        o_cmd.cell_index = i_cell_index;
        o_cmd.col        = (i_target_column > X_W'(COLUMNS - 1)) ?
                           X_W'(COLUMNS - 1) : i_target_column;
        o_cmd.row        = (i_target_row > Y_W'(ROWS - 1)) ?
                           Y_W'(ROWS - 1) : i_target_row;
    end

endmodule

>>> rtl/tcce_back.sv
module tcce_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [tcce_pkg::ATTR_W-1:0]    i_attr,
    input  logic                           i_empty,
    input  tcce_pkg::t_cmd                 i_cmd,
    output logic                           o_pop,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [tcce_pkg::DATA_W-1:0]    o_cell_data,
    output logic [tcce_pkg::OFF_W-1:0]     o_cursor_offset
);
    import tcce_pkg::*;

    // screen store, addressed through the row ring
    logic [DATA_W-1:0] r_cells [CELLS];
    logic [DATA_W-1:0] r_rd_data;

    t_state             r_state;
    t_state             n_state;
    t_cmd               r_cmd;
    logic [X_W-1:0]     r_x;
    logic [X_W-1:0]     n_x;
    logic [Y_W-1:0]     r_y;
    logic [Y_W-1:0]     n_y;
    logic [AW-1:0]      r_lin;
    logic [AW-1:0]      n_lin;
    logic [AW-1:0]      r_top;
    logic [AW-1:0]      r_fill_addr;
    logic [CNT_W-1:0]   r_fill_cnt;
    logic [ATTR_W-1:0]  r_fill_attr;
    logic               r_fill_emit;
    logic               r_rd_ok;
    logic               r_out_valid;
    logic [DATA_W-1:0]  r_out_data;
    logic [OFF_W-1:0]   r_out_off;

    logic [X_W:0]       x_inc;
    logic [X_W:0]       x_tab;
    logic [Y_W:0]       y_wide;
    logic               scroll;
    logic               is_clear;
    logic               idx_ok;
    logic [AW-1:0]      bs_lin;
    logic [AW-1:0]      wr_addr;
    logic [DATA_W-1:0]  wr_data;
    logic [AW-1:0]      rd_addr;
    logic               fill_last;
    logic               out_free;

    logic               exec;
    logic               mem_we;
    logic               mem_re;
    logic               out_load;
    logic               fill_start;
    logic               fill_step;

    assign o_out_valid     = r_out_valid;
    assign o_cell_data     = r_out_data;
    assign o_cursor_offset = r_out_off;

    assign out_free  = !r_out_valid || !i_out_stall;
    assign fill_last = (r_fill_cnt == CNT_W'(1));
    assign n_lin     = AW'(r_y) * AW'(COLUMNS) + AW'(r_x);

    // cursor update for the operation in hand
    always_comb begin
        x_inc  = {1'b0, r_x} + 1'b1;
        x_tab  = {1'b0, r_x} + (X_W+1)'(TAB_STEP);
        n_x    = r_x;
        y_wide = {1'b0, r_y};
        case (r_cmd.op)
            OP_CR: begin
                n_x = '0;
            end
            OP_LF: begin
                n_x    = '0;
                y_wide = {1'b0, r_y} + 1'b1;
            end
            OP_BS: begin
                if (r_x != '0) begin
                    n_x = r_x - 1'b1;
                end else if (r_y != '0) begin
                    n_x    = X_W'(COLUMNS - 1);
                    y_wide = {1'b0, r_y} - 1'b1;
                end
            end
            OP_TAB: begin
                if (x_tab >= (X_W+1)'(COLUMNS)) begin
                    n_x    = '0;
                    y_wide = {1'b0, r_y} + 1'b1;
                end else begin
                    n_x = x_tab[X_W-1:0];
                end
            end
            OP_PUT: begin
                if (x_inc >= (X_W+1)'(COLUMNS)) begin
                    n_x    = '0;
                    y_wide = {1'b0, r_y} + 1'b1;
                end else begin
                    n_x = x_inc[X_W-1:0];
                end
            end
            OP_SET: begin
                n_x    = r_cmd.col;
                y_wide = {1'b0, r_cmd.row};
            end
            OP_CLEAR: begin
                n_x    = '0;
                y_wide = '0;
            end
            default: begin
                n_x = r_x;
            end
        endcase
        scroll   = (y_wide >= (Y_W+1)'(ROWS));
        n_y      = scroll ? Y_W'(ROWS - 1) : y_wide[Y_W-1:0];
        is_clear = (r_cmd.op == OP_CLEAR);
    end

    // store addressing: cursor or fill sweep for writes, cell index for reads
    always_comb begin
        bs_lin  = (r_lin == '0) ? '0 : r_lin - 1'b1;
        idx_ok  = int'(r_cmd.cell_index) < CELLS;
        rd_addr = cell_wrap(AW'(r_cmd.cell_index), r_top);
        if (r_state == ST_FILL) begin
            wr_addr = r_fill_addr;
            wr_data = {r_fill_attr, BLANK_CHAR};
        end else if (r_cmd.op == OP_BS) begin
            wr_addr = cell_wrap(bs_lin, r_top);
            wr_data = {i_attr, BLANK_CHAR};
        end else begin
            wr_addr = cell_wrap(r_lin, r_top);
            wr_data = {i_attr, r_cmd.char_code};
        end
    end

    // sequencer: next state
    always_comb begin
        unique case (r_state)
            ST_FILL: begin
                if (fill_last) begin
                    n_state = r_fill_emit ? ST_EMIT : ST_IDLE;
                end else begin
                    n_state = ST_FILL;
                end
            end
            ST_IDLE: begin
                n_state = i_empty ? ST_IDLE : ST_EXEC;
            end
            ST_EXEC: begin
                n_state = (scroll || is_clear) ? ST_FILL : ST_EMIT;
            end
            ST_EMIT: begin
                if (!out_free) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = i_empty ? ST_IDLE : ST_EXEC;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer: strobes
    always_comb begin
        o_pop      = 1'b0;
        exec       = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        out_load   = 1'b0;
        fill_start = 1'b0;
        fill_step  = 1'b0;
        unique case (r_state)
            ST_FILL: begin
                mem_we    = 1'b1;
                fill_step = 1'b1;
            end
            ST_IDLE: begin
                o_pop = !i_empty;
            end
            ST_EXEC: begin
                exec       = 1'b1;
                mem_we     = (r_cmd.op == OP_PUT) || (r_cmd.op == OP_BS);
                mem_re     = (r_cmd.op == OP_READ);
                fill_start = scroll || is_clear;
            end
            ST_EMIT: begin
                out_load = out_free;
                o_pop    = out_free && !i_empty;
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    // screen store
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_cells[wr_addr] <= wr_data;
        end
        if (mem_re) begin
            r_rd_data <= r_cells[rd_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FILL;
            r_x         <= '0;
            r_y         <= '0;
            r_top       <= '0;
            r_fill_addr <= '0;
            r_fill_cnt  <= CNT_W'(CELLS);
            r_fill_attr <= RESET_ATTR;
            r_fill_emit <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (exec) begin
                r_x <= n_x;
                r_y <= n_y;
            end
            if (fill_start) begin
                r_fill_attr <= i_attr;
                r_fill_emit <= 1'b1;
                if (is_clear) begin
                    r_top       <= '0;
                    r_fill_addr <= '0;
                    r_fill_cnt  <= CNT_W'(CELLS);
                end else begin
                    // old top row becomes the new bottom row
                    r_top       <= cell_wrap(r_top, AW'(COLUMNS));
                    r_fill_addr <= r_top;
                    r_fill_cnt  <= CNT_W'(COLUMNS);
                end
            end else if (fill_step) begin
                r_fill_addr <= r_fill_addr + 1'b1;
                r_fill_cnt  <= r_fill_cnt - 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_lin <= n_lin;
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (exec) begin
            r_rd_ok <= idx_ok;
        end
        if (out_load) begin
            r_out_data <= (r_cmd.op == OP_READ && r_rd_ok) ? r_rd_data : '0;
            r_out_off  <= OFF_W'(n_lin);
        end
    end

endmodule
